// ----- rtl/bqc_pkg.sv -----
// Shared types and constants for the biquad cascade filter.
// No dependencies; used by bqc_cell and the top level.
`timescale 1ns / 1ps
package bqc_pkg;

    localparam int SECTIONS_DEF = 4;
    localparam int HIST_W       = 40;
    localparam int COEF_W       = 24;
    localparam int SAMPLE_W     = 32;
    localparam int Q_FRAC       = 20;
    localparam int NUM_SLOTS    = 5;
    localparam int SEC_W        = 4;
    localparam int SLOT_W       = 3;
    localparam int PROD_W       = HIST_W + COEF_W;
    localparam int ACC_W        = PROD_W + 3;

    localparam logic [1:0] MODE_FILTER = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    localparam logic signed [HIST_W-1:0] OUT_MAX = 40'sd2147483647;
    localparam logic signed [HIST_W-1:0] OUT_MIN = -40'sd2147483648;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic [SEC_W-1:0]         coef_section;
        logic [SLOT_W-1:0]        coef_slot;
        logic signed [COEF_W-1:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                     clamped;
    } t_out;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                     clr;
        logic                     wr_en;
        logic [SEC_W-1:0]         wr_sec;
        logic [SLOT_W-1:0]        wr_slot;
        logic signed [COEF_W-1:0] wr_val;
    } t_cell_ctl;

endpackage

// ----- rtl/bqc_cell.sv -----
// One biquad section: coefficients, histories and a shared multiply-accumulate.
// Depends on bqc_pkg.
`timescale 1ns / 1ps
module bqc_cell #(
    parameter logic [bqc_pkg::SEC_W-1:0] SEC_IDX = '0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bqc_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_start,
    input  logic signed [bqc_pkg::HIST_W-1:0]  i_x,
    output logic                               o_done,
    output logic signed [bqc_pkg::HIST_W-1:0]  o_y
);
    import bqc_pkg::*;

    localparam logic signed [ACC_W-1:0] H_MAX  = (ACC_W'(1) <<< (HIST_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] H_MIN  = -(ACC_W'(1) <<< (HIST_W - 1));
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (Q_FRAC - 1);
    localparam logic [2:0]              LAST_K = 3'(NUM_SLOTS - 1);
    localparam logic [2:0]              FIN_K  = 3'(NUM_SLOTS + 1);

    logic signed [COEF_W-1:0] r_c [NUM_SLOTS];
    logic signed [HIST_W-1:0] r_x0, r_x1, r_x2, r_y1, r_y2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_pv, r_pneg, r_busy;
    logic [2:0]               r_cnt;

    logic signed [HIST_W-1:0] w_oph;
    logic [2:0]               w_idx;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [ACC_W-1:0]  w_prod_x, w_rnd;
    logic signed [HIST_W-1:0] w_y;
    logic                     w_fin;

    always_comb begin
        w_idx = (r_cnt <= LAST_K) ? r_cnt : SLOT_B0;
        case (w_idx)
            SLOT_B0: w_oph = r_x0;
            SLOT_B1: w_oph = r_x1;
            SLOT_B2: w_oph = r_x2;
            SLOT_A1: w_oph = r_y1;
            SLOT_A2: w_oph = r_y2;
            default: w_oph = r_x0;
        endcase
        w_mul    = w_oph * r_c[w_idx];
        w_prod_x = ACC_W'(r_prod);
        // floor((sum + half) / 2^Q), then clamp to the history width
        w_rnd    = (r_acc + RND) >>> Q_FRAC;
        if (w_rnd > H_MAX)      w_y = H_MAX[HIST_W-1:0];
        else if (w_rnd < H_MIN) w_y = H_MIN[HIST_W-1:0];
        else                    w_y = w_rnd[HIST_W-1:0];
        w_fin = r_busy && (r_cnt == FIN_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
            r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) r_c[k] <= '0;
        end else begin
            if (i_ctl.wr_en && i_ctl.wr_sec == SEC_IDX && i_ctl.wr_slot <= LAST_K) begin
                r_c[i_ctl.wr_slot] <= i_ctl.wr_val;
            end
            if (i_ctl.clr) begin
                r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_pv   <= 1'b0;
                r_x0   <= i_x;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 3'd1;
                r_pv   <= (r_cnt <= LAST_K);
                r_pneg <= (r_cnt >= SLOT_A1);
                r_prod <= w_mul;
                if (r_pv) r_acc <= r_pneg ? r_acc - w_prod_x : r_acc + w_prod_x;
                if (w_fin) begin
                    r_busy <= 1'b0;
                    r_x2 <= r_x1; r_x1 <= r_x0;
                    r_y2 <= r_y1; r_y1 <= w_y;
                end
            end
        end
    end

    assign o_done = w_fin;
    assign o_y    = w_y;

endmodule

// ----- rtl/biquad_cascade_iir_filter_top.sv -----
// Top level of the biquad cascade: request handshake, cell chain, output register.
// Depends on bqc_pkg and bqc_cell.
`timescale 1ns / 1ps
// A filter request (mode 0) passes through SECTIONS cells in turn; each cell
// runs its five products through one 40x24 multiplier and an accumulator,
// and a new request is taken only once the chain has finished and no result
// is held aside. Coefficient writes (mode 1) and history clears (mode 2)
// give no result. One finished result may wait on the output while the next
// sample runs.
module biquad_cascade_iir_filter_top #(
    parameter int SECTIONS = bqc_pkg::SECTIONS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bqc_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bqc_pkg::t_out  o_data
);
    import bqc_pkg::*;

    logic                     r_busy, r_start, r_ov, r_pend;
    t_out                     r_out, r_hold;
    t_cell_ctl                w_ctl;
    logic [SECTIONS-1:0]      w_done;
    logic signed [HIST_W-1:0] w_y [SECTIONS];
    logic signed [HIST_W-1:0] r_x;
    logic                     w_acc;
    t_out                     w_res;

    assign o_ready = !r_busy && !r_pend;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_ctl.clr     = w_acc && i_data.mode == MODE_CLEAR;
        w_ctl.wr_en   = w_acc && i_data.mode == MODE_COEF;
        w_ctl.wr_sec  = i_data.coef_section;
        w_ctl.wr_slot = i_data.coef_slot;
        w_ctl.wr_val  = i_data.coef_value;
        if (w_y[SECTIONS-1] > OUT_MAX) begin
            w_res.filtered = OUT_MAX[SAMPLE_W-1:0];
            w_res.clamped  = 1'b1;
        end else if (w_y[SECTIONS-1] < OUT_MIN) begin
            w_res.filtered = OUT_MIN[SAMPLE_W-1:0];
            w_res.clamped  = 1'b1;
        end else begin
            w_res.filtered = w_y[SECTIONS-1][SAMPLE_W-1:0];
            w_res.clamped  = 1'b0;
        end
    end

    genvar s;
    generate
        for (s = 0; s < SECTIONS; s++) begin : g_cell
            bqc_cell #(.SEC_IDX(SEC_W'(s))) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_start ((s == 0) ? r_start : w_done[(s == 0) ? 0 : s - 1]),
                .i_x     ((s == 0) ? r_x : w_y[(s == 0) ? 0 : s - 1]),
                .o_done  (w_done[s]),
                .o_y     (w_y[s])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_start <= w_acc && i_data.mode == MODE_FILTER;
            if (w_acc && i_data.mode == MODE_FILTER) begin
                r_busy <= 1'b1;
                r_x    <= HIST_W'(i_data.sample);
            end
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (r_pend && (!r_ov || i_ready)) begin
                r_out  <= r_hold;
                r_ov   <= 1'b1;
                r_pend <= 1'b0;
            end
            if (w_done[SECTIONS-1]) begin
                r_busy <= 1'b0;
                // hold the result aside while the output register is still full
                if (r_ov && !i_ready) begin
                    r_hold <= w_res;
                    r_pend <= 1'b1;
                end else begin
                    r_out <= w_res;
                    r_ov  <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_busy) else $error("pending result while chain busy");
    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done)) else $error("two cells finished together");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[SECTIONS-1] |-> r_busy && !r_pend) else $error("result without request");
    a_pend_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_ov) else $error("pending result with empty output");

endmodule

// ----- verif/biquad_cascade_iir_filter_top_tb.sv -----
// Testbench for the biquad cascade filter: drives filter, coefficient and clear requests
// and checks every output sample against a fixed-point model of the cascade.
// Depends on bqc_pkg and biquad_cascade_iir_filter_top.
`timescale 1ns / 1ps
module biquad_cascade_iir_filter_top_tb;
    import bqc_pkg::*;

    localparam int NSEC = SECTIONS_DEF;
    localparam logic signed [63:0] HMAX = 64'sd549755813887;
    localparam logic signed [63:0] HMIN = -64'sd549755813888;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    t_in  i_data;
    t_out o_data;

    biquad_cascade_iir_filter_top #(.SECTIONS(NSEC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // model state
    logic signed [COEF_W-1:0] coefs [NSEC*NUM_SLOTS];
    logic signed [63:0] x_hist [NSEC*2];
    logic signed [63:0] y_hist [NSEC*2];
    t_out expected_samples[$];

    int errors, n_filter, n_coef, n_clear, n_clamped;
    int send_idle_pct, recv_stall_pct, hold_off;

    // direct rows: request plus optional hand-typed expectation
    typedef struct {
        t_in  req;
        logic known;
        t_out res;
    } t_row;

    function automatic logic signed [63:0] sat64(logic signed [63:0] v,
                                                 logic signed [63:0] lo,
                                                 logic signed [63:0] hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // exact 128-bit sum, round half up from Q.20, clamp to 40 bits
    function automatic logic signed [63:0] biquad_section(int s, logic signed [63:0] x0);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        logic signed [63:0] y;
        acc = 128'(x0) * 128'(coefs[s*5+0])
            + 128'(x_hist[2*s]) * 128'(coefs[s*5+1])
            + 128'(x_hist[2*s+1]) * 128'(coefs[s*5+2])
            - 128'(y_hist[2*s]) * 128'(coefs[s*5+3])
            - 128'(y_hist[2*s+1]) * 128'(coefs[s*5+4]);
        q = (acc + (128'sd1 <<< (Q_FRAC-1))) >>> Q_FRAC;
        if (q > 128'(HMAX)) y = HMAX;
        else if (q < 128'(HMIN)) y = HMIN;
        else y = 64'(q);
        x_hist[2*s+1] = x_hist[2*s];
        x_hist[2*s]   = x0;
        y_hist[2*s+1] = y_hist[2*s];
        y_hist[2*s]   = y;
        return y;
    endfunction

    task automatic clear_histories();
        for (int i = 0; i < NSEC*2; i++) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
        end
    endtask

    // apply one accepted request to the model; queue a result for filter requests
    task automatic predict_request(t_in r);
        logic signed [63:0] v, c;
        t_out e;
        case (r.mode)
            MODE_FILTER: begin
                v = 64'(r.sample);
                for (int s = 0; s < NSEC; s++) v = biquad_section(s, v);
                c = sat64(v, 64'(OUT_MIN), 64'(OUT_MAX));
                e.filtered = c[31:0];
                e.clamped  = (c != v);
                expected_samples.push_back(e);
                n_filter++;
            end
            MODE_COEF: begin
                if (r.coef_section < NSEC && r.coef_slot <= SLOT_A2)
                    coefs[r.coef_section*5 + r.coef_slot] = r.coef_value;
                n_coef++;
            end
            MODE_CLEAR: begin
                clear_histories();
                n_clear++;
            end
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("Test completed with failures");
        $finish;
    end

    // output side: random stall, long hold-off on demand, compare
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result filtered=%0d", o_data.filtered);
                    errors++;
                end else begin
                    t_out e;
                    e = expected_samples.pop_front();
                    if (o_data.filtered !== e.filtered) begin
                        $error("filtered: expected %0d actual %0d", e.filtered, o_data.filtered);
                        errors++;
                    end
                    if (o_data.clamped !== e.clamped) begin
                        $error("clamped: expected %0b actual %0b", e.clamped, o_data.clamped);
                        errors++;
                    end
                    if (e.clamped) n_clamped++;
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(t_in r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data  <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(r);
    endtask

    task automatic go_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in coef_req(int sec, int slot, int val);
        t_in r;
        r = '0;
        r.mode = MODE_COEF;
        r.coef_section = SEC_W'(sec);
        r.coef_slot = SLOT_W'(slot);
        r.coef_value = COEF_W'(val);
        return r;
    endfunction

    function automatic t_in filt_req(logic [31:0] s);
        t_in r;
        r = t_in'({$urandom, $urandom, $urandom});
        r.mode = MODE_FILTER;
        r.sample = s;
        return r;
    endfunction

    // gentle random coefficients keep most outputs in range; sometimes wild ones
    function automatic int rand_coef(int slot, bit wild);
        if (wild) return $urandom;
        if (slot <= SLOT_B2) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        if (slot == SLOT_A1) return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    task automatic random_phase(int n);
        t_in r;
        int k;
        bit wild;
        wild = ($urandom_range(3) == 0);
        for (int s = 0; s < NSEC; s++)
            for (int k2 = 0; k2 < NUM_SLOTS; k2++) send_request(coef_req(s, k2, rand_coef(k2, wild)));
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 80) begin
                case ($urandom_range(3))
                    0: r = filt_req($urandom);
                    1: r = filt_req($signed($urandom_range(0, 2000)) - 1000);
                    2: r = filt_req($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
                    default: r = filt_req($signed($urandom_range(0, 1 << 24)) - (1 << 23));
                endcase
            end else if (k < 90) begin
                r = t_in'({$urandom, $urandom, $urandom});
                r.mode = MODE_COEF;
                if (r.coef_section < NSEC && r.coef_slot <= SLOT_A2)
                    r.coef_value = COEF_W'(rand_coef(int'(r.coef_slot), wild));
            end else if (k < 95) begin
                r = t_in'({$urandom, $urandom, $urandom});
                r.mode = MODE_CLEAR;
            end else begin
                r = t_in'({$urandom, $urandom, $urandom});
                r.mode = MODE_UNUSED;
            end
            send_request(r);
        end
    endtask

    t_row dir_rows[$];
    t_row row;

    initial begin
        i_valid = 0;
        i_data  = '0;
        i_rst_n = 0;
        errors = 0; n_filter = 0; n_coef = 0; n_clear = 0; n_clamped = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
        for (int i = 0; i < NSEC*NUM_SLOTS; i++) coefs[i] = 0;
        clear_histories();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero coefficients after reset give zero out
        dir_rows.push_back('{filt_req(32'h7fffffff), 1, '{32'sd0, 1'b0}});
        dir_rows.push_back('{filt_req(32'h80000000), 1, '{32'sd0, 1'b0}});
        // unity pass-through in every section
        for (int s = 0; s < NSEC; s++) dir_rows.push_back('{coef_req(s, SLOT_B0, 1 << 20), 0, '0});
        dir_rows.push_back('{filt_req(32'h7fffffff), 1, '{32'sh7fffffff, 1'b0}});
        dir_rows.push_back('{filt_req(32'h80000000), 1, '{-32'sh80000000, 1'b0}});
        // gain of 2 in section 0 drives the output into saturation
        dir_rows.push_back('{coef_req(0, SLOT_B0, 2 << 20), 0, '0});
        dir_rows.push_back('{filt_req(32'h7fffffff), 1, '{32'sh7fffffff, 1'b1}});
        dir_rows.push_back('{filt_req(32'h80000000), 1, '{-32'sh80000000, 1'b1}});
        // extreme coefficients and feedback push sections into 40-bit clamp
        dir_rows.push_back('{coef_req(0, SLOT_B0, 24'h7fffff), 0, '0});
        dir_rows.push_back('{coef_req(0, SLOT_B1, 24'h800000), 0, '0});
        dir_rows.push_back('{coef_req(1, SLOT_B2, 24'h7fffff), 0, '0});
        dir_rows.push_back('{coef_req(1, SLOT_A1, 24'h800000), 0, '0});
        dir_rows.push_back('{coef_req(2, SLOT_A2, 24'h7fffff), 0, '0});
        // ignored writes: section and slot out of range
        dir_rows.push_back('{coef_req(15, SLOT_B0, 0), 0, '0});
        dir_rows.push_back('{coef_req(0, 7, 0), 0, '0});
        dir_rows.push_back('{filt_req(32'h7fffffff), 0, '0});
        dir_rows.push_back('{filt_req(32'h80000000), 0, '0});
        dir_rows.push_back('{filt_req(32'h00000001), 0, '0});
        begin
            t_in r;
            r = '1; r.mode = MODE_UNUSED;
            dir_rows.push_back('{r, 0, '0});
            r = '1; r.mode = MODE_CLEAR; // wipe histories
            dir_rows.push_back('{r, 0, '0});
        end
        dir_rows.push_back('{filt_req(32'hffffffff), 0, '0});

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.known) begin
                send_request(row.req);
                void'(expected_samples.pop_back());
                expected_samples.push_back(row.res);
            end else begin
                send_request(row.req);
            end
        end
        go_idle();

        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(100);
        send_idle_pct = 55; recv_stall_pct = 0;  random_phase(80);
        send_idle_pct = 0;  recv_stall_pct = 55; random_phase(80);
        // long receiver hold-off while requests keep coming
        hold_off = 400;
        send_idle_pct = 33; recv_stall_pct = 33; random_phase(100);

        go_idle();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d filter, %0d coefficient, %0d clear requests; %0d clamped outputs.",
                 n_filter, n_coef, n_clear, n_clamped);
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
